// ----- rtl/gmatch_pkg.sv -----
// Package of the wildcard glob matcher: field widths, command and register
// codes, pattern character constants, the per-cell control struct and case folding.
// Used by every other file of the block except gmatch_out_buf; depends on nothing.
package gmatch_pkg;

  localparam int PatternMaxDef = 64;

  localparam int CmdW     = 2;
  localparam int PosW     = 6;
  localparam int CharW    = 8;
  localparam int CfgLenW  = 7;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 7;

  typedef enum logic [CmdW-1:0] {
    CmdWrite = 2'd0,
    CmdChar  = 2'd1,
    CmdEnd   = 2'd2
  } cmd_e;

  localparam logic [CfgIdxW-1:0] RegPatternLength = 1'b0;
  localparam logic [CfgIdxW-1:0] RegIgnoreCase    = 1'b1;

  localparam logic [CharW-1:0] StarChar  = 8'h2A;
  localparam logic [CharW-1:0] AnyChar   = 8'h3F;
  localparam logic [CharW-1:0] UpperLow  = 8'h41;
  localparam logic [CharW-1:0] UpperHigh = 8'h5A;
  localparam logic [CharW-1:0] CaseShift = 8'h20;

  // Broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic               step;
    logic               restart;
    logic               wr_en;
    logic [PosW-1:0]    wr_pos;
    logic [CharW-1:0]   wr_char;
    logic [CharW-1:0]   sub_char;
    logic               fold_en;
    logic [CfgLenW-1:0] len;
  } cell_ctrl_t;

  function automatic logic [CharW-1:0] fold_char(input logic [CharW-1:0] c,
                                                 input logic en);
    logic [CharW-1:0] r;
    r = c;
    if (en && (c >= UpperLow) && (c <= UpperHigh)) begin
      r = c + CaseShift;
    end
    return r;
  endfunction

endpackage

// ----- rtl/gmatch_if.sv -----
// Valid/ready channel interfaces of the wildcard glob matcher.
// Depends on gmatch_pkg for the field widths.
interface gmatch_in_if;
  logic                        valid;
  logic                        ready;
  logic [gmatch_pkg::CmdW-1:0]  command;
  logic [gmatch_pkg::PosW-1:0]  position;
  logic [gmatch_pkg::CharW-1:0] character;

  modport source (output valid, output command, output position, output character,
                  input ready);
  modport sink (input valid, input command, input position, input character,
                output ready);
endinterface

interface gmatch_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink (input valid, input matched, output ready);
endinterface

// ----- rtl/gmatch_cell.sv -----
// One pattern position of the matcher chain: holds the pattern byte and the
// live bit of its position. Depends on gmatch_pkg.
module gmatch_cell #(
  parameter int Index = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gmatch_pkg::cell_ctrl_t ctrl_i,
  input  logic                   carry_i,
  input  logic                   adv_i,
  output logic                   carry_o,
  output logic                   adv_o,
  output logic                   closed_o
);

  logic [gmatch_pkg::CharW-1:0] char_q, char_d;
  logic                         act_q, act_d;
  logic                         en;
  logic                         star;
  logic                         hit;

  // Position is in use only below the pattern length.
  assign en     = ctrl_i.len > gmatch_pkg::CfgLenW'(Index);
  assign star   = (char_q == gmatch_pkg::StarChar);
  assign hit    = (char_q == gmatch_pkg::AnyChar) ||
                  (gmatch_pkg::fold_char(char_q, ctrl_i.fold_en) == ctrl_i.sub_char);

  // A live star also makes the following position live; this ripples along the chain.
  assign closed_o = act_q | carry_i;
  assign carry_o  = closed_o & star & en;
  assign adv_o    = closed_o & en & ~star & hit;

  always_comb begin
    char_d = char_q;
    if (ctrl_i.wr_en && (ctrl_i.wr_pos == gmatch_pkg::PosW'(Index))) begin
      char_d = ctrl_i.wr_char;
    end
  end

  always_comb begin
    act_d = act_q;
    if (ctrl_i.step) begin
      act_d = (closed_o & star & en) | adv_i;
    end else if (ctrl_i.restart) begin
      act_d = (Index == 0);
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= (Index == 0);
    end else begin
      act_q <= act_d;
    end
  end

endmodule

// ----- rtl/gmatch_out_buf.sv -----
// Output register with a skid stage for the match result words.
// Depends on gmatch_out_if.
module gmatch_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic            matched_i,
  output logic            ready_o,
  gmatch_out_if.source    out_o
);

  logic out_valid_q, out_valid_d;
  logic out_data_q, out_data_d;
  logic skid_valid_q, skid_valid_d;
  logic skid_data_q, skid_data_d;
  logic drain;

  assign drain   = out_valid_q & out_o.ready;
  assign ready_o = ~skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (drain) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || drain) begin
        out_valid_d = 1'b1;
        out_data_d  = matched_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = matched_i;
      end
    end else if (drain) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.matched = out_data_q;

endmodule

// ----- rtl/wildcard_glob_matcher_unit.sv -----
// Top level of the wildcard glob matcher: configuration registers, a chain of
// pattern cells and the result buffer. Depends on gmatch_pkg, gmatch_if,
// gmatch_cell and gmatch_out_buf.
//
//  channel  direction  word fields                        handshake
//  in_i     sink       command[1:0] position[5:0] char[7:0]  valid/ready
//  out_o    source     matched                            valid/ready
//  cfg      write      cfg_idx_i[0] cfg_data_i[6:0]       cfg_we_i
//
// One input word is taken every cycle while in_i.ready is high; a subject byte updates all
// positions in the cycle it is accepted, the star closure rippling through the cell chain.
// A match word shows on out_o in the cycle after its end-of-subject word is accepted
// when the output register is free or drains that cycle; otherwise it waits in the skid stage.
// After reset position zero alone is live; pattern bytes are undefined until written.
// in_i.ready drops only while both the output register and the skid stage hold a word.
module wildcard_glob_matcher_unit #(
  parameter int PatternMax = gmatch_pkg::PatternMaxDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gmatch_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gmatch_pkg::CfgDataW-1:0] cfg_data_i,
  gmatch_in_if.sink                      in_i,
  gmatch_out_if.source                   out_o
);

  localparam int LenW = $clog2(PatternMax + 1);

  logic [gmatch_pkg::CfgLenW-1:0] len_q;
  logic                           ignore_case_q;
  logic [LenW-1:0]                len_sat;
  logic                           in_accept;
  logic                           buf_ready;
  logic                           end_q, end_d;
  logic [PatternMax:0]            carry;
  logic [PatternMax:0]            adv;
  logic [PatternMax:0]            closed;
  gmatch_pkg::cell_ctrl_t         ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q         <= '0;
      ignore_case_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gmatch_pkg::RegPatternLength: len_q         <= cfg_data_i;
        gmatch_pkg::RegIgnoreCase:    ignore_case_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign len_sat = (len_q > gmatch_pkg::CfgLenW'(PatternMax)) ? LenW'(PatternMax)
                                                              : len_q[LenW-1:0];

  assign in_i.ready = buf_ready;
  assign in_accept  = in_i.valid & buf_ready;

  always_comb begin
    ctrl          = '0;
    ctrl.wr_pos   = in_i.position;
    ctrl.wr_char  = in_i.character;
    ctrl.fold_en  = ignore_case_q;
    ctrl.sub_char = gmatch_pkg::fold_char(in_i.character, ignore_case_q);
    ctrl.len      = gmatch_pkg::CfgLenW'(len_sat);
    if (in_accept) begin
      case (gmatch_pkg::cmd_e'(in_i.command))
        gmatch_pkg::CmdWrite: ctrl.wr_en   = 1'b1;
        gmatch_pkg::CmdChar:  ctrl.step    = 1'b1;
        gmatch_pkg::CmdEnd:   ctrl.restart = 1'b1;
        default: ;
      endcase
    end
  end

  assign carry[0] = 1'b0;
  assign adv[0]   = 1'b0;

  for (genvar i = 0; i < PatternMax; i++) begin : g_cell
    gmatch_cell #(
      .Index (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .carry_i  (carry[i]),
      .adv_i    (adv[i]),
      .carry_o  (carry[i+1]),
      .adv_o    (adv[i+1]),
      .closed_o (closed[i])
    );
  end

  // Live bit of the position past the last pattern byte.
  assign closed[PatternMax] = end_q | carry[PatternMax];

  always_comb begin
    end_d = end_q;
    if (ctrl.step) begin
      end_d = adv[PatternMax];
    end else if (ctrl.restart) begin
      end_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_q <= 1'b0;
    end else begin
      end_q <= end_d;
    end
  end

  gmatch_out_buf u_out_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (ctrl.restart),
    .matched_i (closed[len_sat]),
    .ready_o   (buf_ready),
    .out_o     (out_o)
  );

endmodule

// ----- rtl/gmatch_checker.sv -----
// Port-level checks of the wildcard glob matcher, bound to its top level.
// Depends on gmatch_pkg and wildcard_glob_matcher_unit.
module gmatch_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [gmatch_pkg::CmdW-1:0]   in_command_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          out_matched_i
);

  // A result word must hold while the sink stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_matched_i))
    else $error("result word dropped or changed while stalled");

  // A new result appears only after an accepted end-of-subject word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |->
      $past(in_valid_i && in_ready_i && (in_command_i == gmatch_pkg::CmdEnd)))
    else $error("result word without an end-of-subject word");

  // Input back-pressure only happens with a result waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result waiting");

  // An end word accepted while the output is free shows up in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_command_i == gmatch_pkg::CmdEnd) &&
      (!out_valid_i || out_ready_i) |=> out_valid_i)
    else $error("end-of-subject word gave no result");

endmodule

bind wildcard_glob_matcher_unit gmatch_checker u_gmatch_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_command_i  (in_i.command),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_matched_i (out_o.matched)
);

// ----- dv/wildcard_glob_matcher_unit_chk.sv -----
`timescale 1ns / 1ps
// Checker of the wildcard glob matcher: follows the register port and both channels,
// keeps its own pattern store and live position set, predicts each match word and
// compares it. Depends on gmatch_pkg and gmatch_if.
module wildcard_glob_matcher_unit_chk
  import gmatch_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  gmatch_in_if                in_mon,
  gmatch_out_if               out_mon,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int Depth = PatternMaxDef;

  logic [CharW-1:0]   pat_mem [Depth];
  logic [Depth:0]     live_set;
  logic [CfgLenW-1:0] len_reg;
  logic               fold_reg;
  logic               match_bits_q [$];
  int                 fails = 0;

  function automatic logic [CharW-1:0] to_lower(logic [CharW-1:0] c);
    // Upper-case letters have bit 5 clear; setting it gives the lower-case letter.
    if (fold_reg && c >= UpperLow && c <= UpperHigh) begin
      return c | CaseShift;
    end
    return c;
  endfunction

  function automatic int used_len();
    return (int'(len_reg) > Depth) ? Depth : int'(len_reg);
  endfunction

  // A live star may match an empty run, so the position after it is live too.
  function automatic logic [Depth:0] spread_stars(logic [Depth:0] s, int n);
    for (int i = 0; i < n; i++) begin
      if (s[i] && pat_mem[i] == StarChar) begin
        s[i+1] = 1'b1;
      end
    end
    return s;
  endfunction

  function automatic logic [Depth:0] consume_byte(logic [Depth:0] s, logic [CharW-1:0] b);
    logic [Depth:0] nxt;
    int n;
    n = used_len();
    nxt = '0;
    s = spread_stars(s, n);
    for (int i = 0; i < n; i++) begin
      if (s[i]) begin
        if (pat_mem[i] == StarChar) begin
          nxt[i] = 1'b1;
        end else if (pat_mem[i] == AnyChar || to_lower(pat_mem[i]) == to_lower(b)) begin
          nxt[i+1] = 1'b1;
        end
      end
    end
    return nxt;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic exp_bit;
    if (!rst_ni) begin
      len_reg = '0;
      fold_reg = 1'b0;
      live_set = (Depth+1)'(1);
      match_bits_q.delete();
    end else begin
      // Results are checked before this edge's input, so a word can only
      // match an end of subject taken on an earlier edge.
      if (out_mon.valid && out_mon.ready) begin
        if (match_bits_q.size() == 0) begin
          $error("matched: no word expected, actual %0b", out_mon.matched);
          fails++;
        end else begin
          exp_bit = match_bits_q.pop_front();
          if (out_mon.matched !== exp_bit) begin
            $error("matched: expected %0b, actual %0b", exp_bit, out_mon.matched);
            fails++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == RegPatternLength) begin
          len_reg = cfg_data_i[CfgLenW-1:0];
        end else begin
          fold_reg = cfg_data_i[0];
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.command)
          CmdWrite: pat_mem[in_mon.position] = in_mon.character;
          CmdChar: live_set = consume_byte(live_set, in_mon.character);
          CmdEnd: begin
            live_set = spread_stars(live_set, used_len());
            match_bits_q.push_back(live_set[used_len()]);
            live_set = (Depth+1)'(1);
          end
          default: ;
        endcase
      end
    end
    fail_count_o = fails;
    pending_o = match_bits_q.size();
  end

endmodule

// ----- dv/wildcard_glob_matcher_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench top of the wildcard glob matcher: clock, reset, register writes and
// command words with random idling on both channels, plus the verdict.
// Depends on gmatch_pkg, gmatch_if, the RTL and wildcard_glob_matcher_unit_chk.
module wildcard_glob_matcher_unit_tb;
  import gmatch_pkg::*;

  localparam int StoreDepth = PatternMaxDef;
  localparam int RandomWords = 800;
  localparam int SettleCycles = 4;
  localparam int LongHoldCycles = 300;
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  typedef enum int {RxAlways, RxHalf, RxSparse, RxPeriodic} rx_mode_e;
  typedef enum int {SubjMatch, SubjMutated, SubjRandom} subj_kind_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  int  fail_count;
  int  pending_count;
  int  ends_sent = 0;
  int  results_seen = 0;
  int  words_done = 0;
  int  burst_left = 0;
  bit  long_hold_req = 1'b0;
  int  pat_len = 0;
  bit  fold_on = 1'b0;
  logic [CharW-1:0] pat_buf [StoreDepth];
  logic [CharW-1:0] subject_q [$];

  gmatch_in_if  in_if ();
  gmatch_out_if out_if ();

  wildcard_glob_matcher_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  wildcard_glob_matcher_unit_chk u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      results_seen <= results_seen + 1;
    end
  end

  // Result side: ready follows a randomly chosen stall pattern; on request it holds
  // off for a long stretch so that the block backs up into its input.
  initial begin
    rx_mode_e mode;
    int cyc;
    mode = RxAlways;
    cyc = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
      end
      if (cyc % 64 == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
      end
      cyc++;
      case (mode)
        RxAlways: out_if.ready <= 1'b1;
        RxHalf:   out_if.ready <= 1'($urandom_range(0, 1));
        RxSparse: out_if.ready <= ($urandom_range(0, 3) == 0);
        default:  out_if.ready <= (cyc % 3 == 0);
      endcase
    end
  end

  // Offers one word, idling between bursts, and returns at the edge that takes it.
  task automatic send_word(logic [CmdW-1:0] cmd, logic [PosW-1:0] pos,
                           logic [CharW-1:0] ch);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        gap = $urandom_range(1, 6);
      end
    end
    burst_left--;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.command <= cmd;
    in_if.position <= pos;
    in_if.character <= ch;
    do @(posedge clk_i); while (!in_if.ready);
    if (cmd == CmdEnd) begin
      ends_sent++;
    end
    if (cmd != CmdUnused) begin
      words_done++;
    end
  endtask

  // Stops sending and waits until every match word is out and the block is quiet.
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (results_seen < ends_sent);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(int len, bit fold);
    write_reg(RegPatternLength, CfgDataW'(len));
    write_reg(RegIgnoreCase, CfgDataW'(fold));
    pat_len = (len > StoreDepth) ? StoreDepth : len;
    fold_on = fold;
  endtask

  task automatic put_entry(int pos, logic [CharW-1:0] ch);
    pat_buf[pos] = ch;
    send_word(CmdWrite, PosW'(pos), ch);
  endtask

  // Letters of both cases plus the two bytes next to the upper-case range.
  function automatic logic [CharW-1:0] pick_letter();
    case ($urandom_range(0, 7))
      0: return 8'h61;
      1: return 8'h41;
      2: return 8'h62;
      3: return 8'h42;
      4: return 8'h5A;
      5: return 8'h7A;
      6: return 8'h40;
      default: return 8'h5B;
    endcase
  endfunction

  function automatic logic [CharW-1:0] rand_pat_char();
    int r;
    r = $urandom_range(0, 15);
    if (r < 3) return StarChar;
    if (r < 5) return AnyChar;
    if (r == 5) return 8'($urandom_range(0, 255));
    return pick_letter();
  endfunction

  task automatic build_subject(subj_kind_e kind);
    logic [CharW-1:0] b;
    subject_q.delete();
    if (kind == SubjRandom) begin
      repeat ($urandom_range(0, 6)) subject_q.push_back(pick_letter());
      return;
    end
    // Walk the pattern and emit a subject that it accepts.
    for (int i = 0; i < pat_len; i++) begin
      b = pat_buf[i];
      if (b == StarChar) begin
        repeat ($urandom_range(0, 3)) subject_q.push_back(pick_letter());
      end else if (b == AnyChar) begin
        subject_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        if (fold_on && ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A))
            && $urandom_range(0, 1) == 1) begin
          b = b ^ 8'h20;
        end
        subject_q.push_back(b);
      end
    end
    if (kind == SubjMutated) begin
      case ($urandom_range(0, 2))
        0: begin
          if (subject_q.size() > 0) subject_q.delete($urandom_range(0, subject_q.size() - 1));
        end
        1: subject_q.insert($urandom_range(0, subject_q.size()), pick_letter());
        default: begin
          if (subject_q.size() > 0) begin
            subject_q[$urandom_range(0, subject_q.size() - 1)] = pick_letter();
          end
        end
      endcase
    end
  endtask

  // Sends the subject and its end word; with noise, ignored words and pattern
  // rewrites are slipped in between subject bytes.
  task automatic send_subject(bit noisy);
    foreach (subject_q[i]) begin
      if (noisy && $urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          send_word(CmdUnused, PosW'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
        end else begin
          put_entry($urandom_range(0, StoreDepth - 1), rand_pat_char());
        end
      end
      send_word(CmdChar, PosW'($urandom_range(0, 63)), subject_q[i]);
    end
    send_word(CmdEnd, PosW'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int base;
    int phase;
    int len;
    int nsub;
    int r;
    in_if.valid = 1'b0;
    in_if.command = CmdWrite;
    in_if.position = '0;
    in_if.character = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset the pattern is empty: only the empty subject matches.
    send_word(CmdEnd, '0, '0);
    send_word(CmdUnused, 6'h3F, 8'hFF);
    send_word(CmdChar, 6'h3F, 8'h00);
    send_word(CmdEnd, '0, 8'hFF);

    // A pattern of stars also matches the empty subject.
    set_config(2, 1'b0);
    put_entry(0, StarChar);
    put_entry(1, StarChar);
    send_word(CmdEnd, '0, '0);

    // Literal letter, any byte and a zero byte, with and without case folding.
    set_config(3, 1'b1);
    put_entry(0, 8'h61);
    put_entry(1, AnyChar);
    put_entry(2, 8'h00);
    subject_q = '{8'h41, 8'hFF, 8'h00};
    send_subject(1'b0);
    subject_q = '{8'h61};
    send_subject(1'b0);
    set_config(3, 1'b0);
    subject_q = '{8'h41, 8'h80, 8'h00};
    send_subject(1'b0);
    subject_q = '{8'h61, StarChar, 8'h00};
    send_subject(1'b0);

    base = words_done;
    phase = 0;
    // The first four phases always run so that the long output stall is never skipped.
    while (phase < 4 || words_done - base < RandomWords) begin
      case (phase)
        0: len = 127;
        1: len = 64;
        2: len = 0;
        3: len = $urandom_range(1, 4);
        default: begin
          r = $urandom_range(0, 19);
          if (r == 0) len = 0;
          else if (r == 1) len = $urandom_range(65, 126);
          else if (r == 2) len = $urandom_range(20, 64);
          else len = $urandom_range(1, 10);
        end
      endcase
      set_config(len, 1'($urandom_range(0, 1)));
      for (int i = 0; i < pat_len; i++) begin
        put_entry(i, rand_pat_char());
      end
      nsub = (pat_len > 20) ? $urandom_range(2, 4) : $urandom_range(4, 14);
      if (phase == 3) begin
        long_hold_req = 1'b1;
        nsub = 30;
      end
      for (int s = 0; s < nsub; s++) begin
        if ($urandom_range(0, 24) == 0) begin
          drain();
        end
        r = $urandom_range(0, 9);
        build_subject(r < 6 ? SubjMatch : (r < 9 ? SubjMutated : SubjRandom));
        send_subject(1'b1);
      end
      phase++;
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (pending_count != 0) begin
      $error("matched: %0d expected words never arrived", pending_count);
    end
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/gmatch_pkg.sv
rtl/gmatch_if.sv
rtl/gmatch_cell.sv
rtl/gmatch_out_buf.sv
rtl/wildcard_glob_matcher_unit.sv
rtl/gmatch_checker.sv
dv/wildcard_glob_matcher_unit_chk.sv
dv/wildcard_glob_matcher_unit_tb.sv
